// ===== hw/rtl/get_pkg.sv =====
// ----------------------------------------------------------------------------
// get_pkg: shared types for the gabriel edge test block
// Item kinds and the control word that travels along the cell chain.
// ----------------------------------------------------------------------------
package get_pkg;

    // what an item in the cell chain asks of each cell
    typedef enum logic [2:0] {
        K_LI   = 3'd0,  // latch coordinate of first point
        K_LJ   = 3'd1,  // latch coordinate of second point
        K_REF  = 3'd2,  // distance between the pair itself
        K_TEST = 3'd3,  // candidate third point
        K_SKIP = 3'd4   // third point equal to one of the pair
    } t_kind;

    // control word handed from cell to cell
    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  last;
    } t_ctl;

endpackage

// ===== hw/rtl/get_ram.sv =====
// ----------------------------------------------------------------------------
// get_ram: generic simple dual-port ram
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module get_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/get_cell.sv =====
// ----------------------------------------------------------------------------
// get_cell: one dimension of the distance chain
// Holds the coordinates of one dimension, squares the differences to the
// query pair and adds them to the partial sum handed in by the previous cell.
// ----------------------------------------------------------------------------
module get_cell import get_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int AW         = 8,
    parameter int DEPTH      = 256,
    parameter int SW         = 37
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [COORD_BITS-1:0] i_wdata,
    input  t_ctl                  i_ctl,
    input  logic [AW-1:0]         i_addr,
    input  logic [SW-1:0]         i_sum,
    output t_ctl                  o_ctl,
    output logic [AW-1:0]         o_addr,
    output t_ctl                  o_sctl,
    output logic [SW-1:0]         o_sum
);

    localparam int PW = 2 * COORD_BITS + 2;

    logic [COORD_BITS-1:0] w_rd;
    t_ctl                  r_ctl1, r_ctl2, r_ctl3;
    logic [AW-1:0]         r_addr;
    logic [COORD_BITS-1:0] r_xi, r_xj;
    logic [PW-1:0]         r_pi, r_pj;
    logic [SW-1:0]         r_sum;
    logic signed [COORD_BITS:0] w_di, w_dj;
    logic signed [PW-1:0]  w_si, w_sj;

    get_ram #(.WIDTH(COORD_BITS), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_we),
        .i_waddr(i_waddr),
        .i_wdata(i_wdata),
        .i_raddr(i_addr),
        .o_rdata(w_rd)
    );

    // differences and squares against the point just read
    always_comb begin
        w_di = $signed({r_xi[COORD_BITS-1], r_xi}) - $signed({w_rd[COORD_BITS-1], w_rd});
        w_dj = $signed({r_xj[COORD_BITS-1], r_xj}) - $signed({w_rd[COORD_BITS-1], w_rd});
        w_si = PW'(w_di) * PW'(w_di);
        w_sj = PW'(w_dj) * PW'(w_dj);
    end

    // control stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    // pair latches, products and chain sum
    always_ff @(posedge i_clk) begin
        r_addr <= i_addr;
        if (r_ctl1.valid && r_ctl1.kind == K_LI) begin
            r_xi <= w_rd;
        end
        if (r_ctl1.valid && r_ctl1.kind == K_LJ) begin
            r_xj <= w_rd;
        end
        r_pi <= i_en ? PW'(w_si) : '0;
        r_pj <= i_en ? PW'(w_sj) : '0;
        r_sum <= i_sum + SW'(r_pi) + SW'(r_pj);
    end

    assign o_ctl  = r_ctl1;
    assign o_addr = r_addr;
    assign o_sctl = r_ctl3;
    assign o_sum  = r_sum;

endmodule

// ===== hw/rtl/gabriel_edge_test.sv =====
// ----------------------------------------------------------------------------
// gabriel_edge_test: gabriel graph edge test over a stored point set
// Loads coordinates into per-dimension cells and tests point pairs.
// ----------------------------------------------------------------------------
// Usage:
//  - slave stream: tuser 0 loads one coordinate (no result),
//    tuser 1 tests the pair (point_index, second_index)
//  - master stream: one item per test with is_edge, bad_pair and the echoed
//    indices
//  - apb port: point_count at 0x0, dim_count at 0x4, written while idle
// Operation:
//  - a valid test: the pair and a reference item enter the cell chain, then
//    one stored point per cycle, and at last the final partial sum leaves it
//  - an invalid pair goes to the output without entering the cell chain
//  - loads are taken one per cycle while no test is running
// Reset clears configuration to point_count 2, dim_count 1 and empties the
// output; stored coordinates are undefined until loaded.
// A stalled receiver holds the result in the output register; one more test
// can finish into a holding stage, and input is refused until the output
// register takes that held result.
// ----------------------------------------------------------------------------
module gabriel_edge_test import get_pkg::*; #(
    parameter int MAX_POINTS = 256,
    parameter int MAX_DIMS   = 8,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] point_index, [15:8] second_index, [18:16] dim_index,
    // [34:19] coord_value, [39:35] zero
    input  logic [39:0] i_s_tdata,
    // [0] mode
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] is_edge, [1] bad_pair, [9:2] first_point, [17:10] second_point,
    // [23:18] zero
    output logic [23:0] o_m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = 2 * COORD_BITS + 2 + $clog2(MAX_DIMS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state      r_state;
    logic [8:0]  r_point_count;
    logic [3:0]  r_dim_count;
    logic [7:0]  r_pi, r_pj;
    logic [1:0]  r_pre;
    logic [AW-1:0] r_k;
    logic        r_edge;
    logic [SW-1:0] r_dij;
    logic        r_res_edge, r_res_bad;
    logic        r_ovalid;
    logic [23:0] r_odata;
    t_ctl        r_ctl0;
    logic [AW-1:0] r_addr0;

    logic [31:0] w_cnt;
    logic        w_acc, w_bad, w_less, w_kskip, w_klast;
    logic        w_out_load;
    logic [7:0]  w_pi, w_pj;
    logic [2:0]  w_dim;
    logic [15:0] w_coord;
    logic [COORD_BITS-1:0] w_fit;
    logic        w_load_ok;

    t_ctl          w_ctl  [MAX_DIMS+1];
    logic [AW-1:0] w_addr [MAX_DIMS+1];
    logic [SW-1:0] w_sum  [MAX_DIMS+1];
    t_ctl          w_sctl [MAX_DIMS];

    // input fields and decode
    always_comb begin
        w_pi    = i_s_tdata[7:0];
        w_pj    = i_s_tdata[15:8];
        w_dim   = i_s_tdata[18:16];
        w_coord = i_s_tdata[34:19];
        for (int b = 0; b < COORD_BITS; b++) begin
            w_fit[b] = w_coord[(b < 16) ? b : 15];
        end
        w_acc     = i_s_tvalid && o_s_tready;
        w_load_ok = (32'(w_pi) < MAX_POINTS) && (32'(w_dim) < MAX_DIMS);
        w_cnt     = (32'(r_point_count) < MAX_POINTS) ? 32'(r_point_count) : MAX_POINTS;
        w_bad     = (w_pi == w_pj) || (32'(w_pi) >= w_cnt) || (32'(w_pj) >= w_cnt);
        w_kskip   = (32'(r_k) == 32'(r_pi)) || (32'(r_k) == 32'(r_pj));
        w_klast   = (32'(r_k) + 32'd1) == w_cnt;
        w_less    = w_sum[MAX_DIMS] < r_dij;
        w_out_load = (r_state == S_OUT) && (!r_ovalid || i_m_tready);
    end

    assign o_s_tready = (r_state == S_IDLE);

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {28'd0, r_dim_count} : {23'd0, r_point_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 9'd2;
            r_dim_count   <= 4'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_dim_count <= pwdata[3:0];
            end else begin
                r_point_count <= pwdata[8:0];
            end
        end
    end

    // sequencer and result collection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ctl0   <= '0;
        end else begin
            // output register
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_ctl0 <= '0;
                    if (w_acc && i_s_tuser) begin
                        r_pi  <= w_pi;
                        r_pj  <= w_pj;
                        r_pre <= 2'd0;
                        r_k   <= '0;
                        r_edge <= 1'b1;
                        if (w_bad) begin
                            r_res_edge <= 1'b0;
                            r_res_bad  <= 1'b1;
                            r_state    <= S_OUT;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    case (r_pre)
                        2'd0: begin
                            r_ctl0  <= '{valid: 1'b1, kind: K_LI, last: 1'b0};
                            r_addr0 <= AW'(r_pi);
                            r_pre   <= 2'd1;
                        end
                        2'd1: begin
                            r_ctl0  <= '{valid: 1'b1, kind: K_LJ, last: 1'b0};
                            r_addr0 <= AW'(r_pj);
                            r_pre   <= 2'd2;
                        end
                        2'd2: begin
                            r_ctl0  <= '{valid: 1'b1, kind: K_REF, last: 1'b0};
                            r_addr0 <= AW'(r_pj);
                            r_pre   <= 2'd3;
                        end
                        default: begin
                            r_ctl0  <= '{valid: 1'b1,
                                         kind: (w_kskip ? K_SKIP : K_TEST),
                                         last: w_klast};
                            r_addr0 <= r_k;
                            r_k     <= r_k + AW'(1);
                            if (w_klast) begin
                                r_state <= S_WAIT;
                            end
                        end
                    endcase
                end
                S_WAIT: begin
                    r_ctl0 <= '0;
                    if (w_sctl[MAX_DIMS-1].valid && w_sctl[MAX_DIMS-1].last) begin
                        r_res_edge <= r_edge &&
                            !(w_sctl[MAX_DIMS-1].kind == K_TEST && w_less);
                        r_res_bad  <= 1'b0;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ctl0 <= '0;
                    if (w_out_load) begin
                        r_odata  <= {6'd0, r_pj, r_pi, r_res_bad, r_res_edge};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_ctl0  <= '0;
                    r_state <= S_IDLE;
                end
            endcase

            // partial sums leaving the chain
            if (w_sctl[MAX_DIMS-1].valid) begin
                if (w_sctl[MAX_DIMS-1].kind == K_REF) begin
                    r_dij <= w_sum[MAX_DIMS];
                end else if (w_sctl[MAX_DIMS-1].kind == K_TEST && w_less) begin
                    r_edge <= 1'b0;
                end
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // chain of per-dimension cells
    assign w_ctl[0]  = r_ctl0;
    assign w_addr[0] = r_addr0;
    assign w_sum[0]  = '0;

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
        get_cell #(
            .COORD_BITS(COORD_BITS),
            .AW        (AW),
            .DEPTH     (MAX_POINTS),
            .SW        (SW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (32'(r_dim_count) > d),
            .i_we   (w_acc && !i_s_tuser && w_load_ok && (32'(w_dim) == d)),
            .i_waddr(AW'(w_pi)),
            .i_wdata(w_fit),
            .i_ctl  (w_ctl[d]),
            .i_addr (w_addr[d]),
            .i_sum  (w_sum[d]),
            .o_ctl  (w_ctl[d+1]),
            .o_addr (w_addr[d+1]),
            .o_sctl (w_sctl[d]),
            .o_sum  (w_sum[d+1])
        );
    end

endmodule

// ===== sim/tb_gabriel_edge_test.sv =====
// ----------------------------------------------------------------------------
// tb_gabriel_edge_test: stream testbench for the gabriel edge test block
// Loads point sets over the slave stream, sends pair tests, and compares
// each result item with a behavioral predictor that keeps its own copy of
// the coordinates and registers. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_gabriel_edge_test;

    localparam int NPTS = 256;
    localparam int NDIM = 8;
    localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;
    localparam logic [2:0] ADDR_DIM_COUNT   = 3'd4;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_PAIR = 1'b1;
    localparam int CYCLE_LIMIT = 3000000;

    // fields listed from the highest bit down, laid out as on o_m_tdata
    typedef struct packed {
        logic [7:0] second_point;
        logic [7:0] first_point;
        logic       bad_pair;
        logic       is_edge;
    } t_pair_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gabriel_edge_test u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic signed [15:0] coord_mem [NPTS*NDIM];
    int unsigned        cfg_points;
    int unsigned        cfg_dims;
    t_pair_result       pending_results[$];
    int                 fail_count;
    bit                 idle_enable;
    longint             cycle_count;

    // clock
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[gabriel_edge_test] ERROR");
            $finish;
        end
    end

    function automatic longint unsigned pair_dist(int p, int q);
        longint unsigned sum;
        longint d;
        sum = 0;
        for (int n = 0; n < int'(cfg_dims) && n < NDIM; n++) begin
            d = longint'(coord_mem[p*NDIM+n]) - longint'(coord_mem[q*NDIM+n]);
            sum += longint'(d * d);
        end
        return sum;
    endfunction

    function automatic t_pair_result predict_pair(int a, int b);
        t_pair_result r;
        int cnt;
        longint unsigned dab;
        cnt = (cfg_points < NPTS) ? cfg_points : NPTS;
        r.first_point = a[7:0];
        r.second_point = b[7:0];
        r.bad_pair = (a == b) || (a >= cnt) || (b >= cnt);
        r.is_edge = 1'b0;
        if (!r.bad_pair) begin
            dab = pair_dist(a, b);
            r.is_edge = 1'b1;
            for (int k = 0; k < cnt; k++) begin
                if (k != a && k != b && pair_dist(a, k) + pair_dist(b, k) < dab) begin
                    r.is_edge = 1'b0;
                    break;
                end
            end
        end
        return r;
    endfunction

    // random sender gap
    task automatic sender_gap();
        if (idle_enable && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
    endtask

    // send one item and update the predictor at acceptance
    task automatic send_item(logic mode, int a, int b, int dim, logic [15:0] val);
        sender_gap();
        i_s_tvalid = 1'b1;
        i_s_tuser = mode;
        i_s_tdata = {5'd0, val, dim[2:0], b[7:0], a[7:0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (mode == MODE_LOAD) begin
            coord_mem[a*NDIM+dim] = val;
        end else begin
            pending_results = {pending_results, predict_pair(a, b)};
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // wait for every expected item, then the block's own latency
    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (NPTS + NDIM + 20) @(negedge i_clk);
    endtask

    task automatic set_config(int pts, int dims);
        drain();
        apb_write(ADDR_POINT_COUNT, pts);
        apb_write(ADDR_DIM_COUNT, dims);
        cfg_points = pts;
        cfg_dims = dims;
    endtask

    // load points 0..pts-1 in dimensions 0..dims-1
    task automatic load_points(int pts, int dims, int spread);
        logic [15:0] v;
        for (int p = 0; p < pts; p++)
            for (int n = 0; n < dims; n++) begin
                if (spread == 0) v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                else v = 16'($urandom_range(0, 2*spread) - spread);
                send_item(MODE_LOAD, p, $urandom_range(0, 255), n, v);
            end
    endtask

    // query a pair, mostly valid, sometimes bad
    task automatic random_pair(int pts);
        int a, b;
        a = $urandom_range(0, pts - 1);
        b = $urandom_range(0, pts - 1);
        case ($urandom_range(0, 9))
            0: b = a;
            1: a = $urandom_range(0, 255);
            2: b = $urandom_range(0, 255);
            default: ;
        endcase
        send_item(MODE_PAIR, a, b, $urandom_range(0, 7), 16'($urandom));
    endtask

    // directed: extremes, bad pairs, default registers
    task automatic test_directed();
        send_item(MODE_LOAD, 0, 8'hff, 7, 16'h7fff);
        send_item(MODE_LOAD, 1, 8'h00, 7, 16'h8000);
        for (int n = 0; n < 7; n++) begin
            send_item(MODE_LOAD, 0, 0, n, 16'h0000);
            send_item(MODE_LOAD, 1, 0, n, 16'hffff);
        end
        send_item(MODE_PAIR, 0, 1, 0, 16'h0);
        send_item(MODE_PAIR, 1, 0, 7, 16'hffff);
        send_item(MODE_PAIR, 0, 0, 0, 16'h0);
        send_item(MODE_PAIR, 2, 1, 0, 16'h0);
        send_item(MODE_PAIR, 255, 0, 0, 16'h0);
        send_item(MODE_PAIR, 0, 255, 0, 16'h0);
        set_config(2, 0);
        send_item(MODE_PAIR, 0, 1, 0, 16'h0);
        set_config(2, 15);
        send_item(MODE_PAIR, 0, 1, 0, 16'h0);
    endtask

    // full-scale coordinates in all dims, then a full store in one dim
    task automatic test_extremes();
        set_config(8, 8);
        load_points(8, NDIM, 0);
        repeat (20) random_pair(8);
        set_config(300, 1);
        load_points(NPTS, 1, 32767);
        repeat (6) random_pair(NPTS);
        send_item(MODE_PAIR, 255, 254, 0, 16'h0);
        set_config(NPTS, 1);
        repeat (4) random_pair(NPTS);
    endtask

    // small point sets, random sizes and dimension counts
    task automatic test_random_sets();
        int pts;
        for (int round = 0; round < 4; round++) begin
            pts = $urandom_range(3, 6);
            set_config(pts, $urandom_range(0, 15));
            load_points(pts, NDIM, $urandom_range(0, 1) ? 20 : 32767);
            repeat (15) random_pair(pts);
            if (round == 1) begin
                // hold off until every result is back
                while (pending_results.size() != 0) @(negedge i_clk);
                repeat (15) random_pair(pts);
            end
        end
    endtask

    // last part with no idling on either side
    task automatic test_no_idle();
        idle_enable = 1'b0;
        set_config(12, 3);
        load_points(12, 3, 100);
        repeat (40) random_pair(12);
    endtask

    // receiver: random stall bursts
    initial begin
        int stall;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 12) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // compare each result item
    always @(posedge i_clk) begin
        t_pair_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[17:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item expected none actual %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected edge=%b bad=%b i=%0d j=%0d actual edge=%b bad=%b i=%0d j=%0d",
                             $time, want.is_edge, want.bad_pair, want.first_point,
                             want.second_point, got.is_edge, got.bad_pair,
                             got.first_point, got.second_point);
                    fail_count++;
                end
            end
        end
    end

    // sequence
    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fail_count = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        cfg_points = 2;
        cfg_dims = 1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_extremes();
        test_random_sets();
        test_no_idle();
        drain();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[gabriel_edge_test] OK");
        else
            $display("[gabriel_edge_test] ERROR");
        $finish;
    end

endmodule
